[hdl/ewjt_pkg.sv]
// Package for the encoder wrap and jitter tracker.
// Holds the word types, the configuration group and the event and state codes.
// No dependencies.
package ewjt_pkg;

	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] CFG_INVERT_MODE       = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_PATTERN_CHECK_EN  = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_CONFIRM_THRESHOLD = 2'd2;

	localparam logic [1:0] FUNC_COMPARE = 2'd0;
	localparam logic [1:0] FUNC_WRAP    = 2'd1;
	localparam logic [1:0] FUNC_HW_UP   = 2'd2;
	localparam logic [1:0] FUNC_HW_DOWN = 2'd3;

	localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
	localparam logic [1:0] DIR_FORWARD  = 2'd1;
	localparam logic [1:0] DIR_BACKWARD = 2'd2;

	localparam logic [2:0] PAT_NONE             = 3'd0;
	localparam logic [2:0] PAT_FWD_EXPECT_BWD   = 3'd1;
	localparam logic [2:0] PAT_BWD_EXPECT_FWD   = 3'd2;
	localparam logic [2:0] PAT_FWD_EXPECT_BWD_E = 3'd3;
	localparam logic [2:0] PAT_BWD_EXPECT_FWD_E = 3'd4;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] count_now;
		logic        up_flag;
		logic        down_flag;
	} evt_word_t;

	typedef struct packed {
		logic [1:0]         direction;
		logic signed [31:0] wrap_count;
		logic [2:0]         pattern_state;
		logic [15:0]        pattern_count;
		logic               compensating;
	} status_word_t;

	typedef struct packed {
		logic        invert_mode;
		logic        pattern_check_enable;
		logic [15:0] confirm_threshold;
	} cfg_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

[hdl/ewjt_core.sv]
// Tracker state and its update for one event word.
// Depends on ewjt_pkg for the word types, codes and configuration group.
module ewjt_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ewjt_pkg::evt_word_t   evt,
	input  ewjt_pkg::cfg_t        cfg,
	output ewjt_pkg::status_word_t nxt
);

	logic [1:0]         dir_q;
	logic signed [31:0] wraps_q;
	logic [2:0]         pat_q;
	logic [15:0]        cnt_q;
	logic               just_q;
	logic               comp_q;
	logic [15:0]        last_q;

	logic [1:0]         dir_d;
	logic signed [31:0] wraps_d;
	logic [2:0]         pat_d;
	logic [15:0]        cnt_d;
	logic               just_d;
	logic               comp_d;
	logic [15:0]        last_d;

	logic               moved;
	logic [2:0]         pat_b;
	logic [15:0]        cnt_b;
	logic [15:0]        cnt_inc;
	logic               just_b;
	logic               forward;

	always_comb begin
		dir_d   = dir_q;
		wraps_d = wraps_q;
		pat_d   = pat_q;
		cnt_d   = cnt_q;
		just_d  = just_q;
		comp_d  = comp_q;
		last_d  = last_q;

		moved   = evt.count_now != last_q;
		pat_b   = moved ? ewjt_pkg::PAT_NONE : pat_q;
		just_b  = moved ? 1'b0 : just_q;
		cnt_b   = (moved && !comp_q) ? 16'd0 : cnt_q;
		cnt_inc = ewjt_pkg::sat_inc(cnt_b);
		forward = (evt.func == ewjt_pkg::FUNC_HW_UP) != cfg.invert_mode;

		case (evt.func)
			ewjt_pkg::FUNC_COMPARE: begin
				if (dir_q == ewjt_pkg::DIR_UNKNOWN) begin
					dir_d = ewjt_pkg::DIR_FORWARD;
				end
			end
			ewjt_pkg::FUNC_WRAP: begin
				if (dir_q == ewjt_pkg::DIR_UNKNOWN) begin
					dir_d = ewjt_pkg::DIR_BACKWARD;
				end
				if (evt.up_flag) begin
					dir_d = cfg.invert_mode ? ewjt_pkg::DIR_BACKWARD : ewjt_pkg::DIR_FORWARD;
				end else if (evt.down_flag) begin
					dir_d = cfg.invert_mode ? ewjt_pkg::DIR_FORWARD : ewjt_pkg::DIR_BACKWARD;
				end
				if (dir_d == ewjt_pkg::DIR_FORWARD) begin
					wraps_d = wraps_q + 32'sd1;
				end else if (dir_d == ewjt_pkg::DIR_BACKWARD) begin
					wraps_d = wraps_q - 32'sd1;
				end
			end
			default: begin
				if (forward) begin
					dir_d = ewjt_pkg::DIR_FORWARD;
					if (cfg.pattern_check_enable && pat_q == ewjt_pkg::PAT_BWD_EXPECT_FWD) begin
						pat_d = ewjt_pkg::PAT_FWD_EXPECT_BWD_E;
					end
				end else begin
					dir_d = ewjt_pkg::DIR_BACKWARD;
					if (cfg.pattern_check_enable) begin
						pat_d  = pat_b;
						just_d = just_b;
						cnt_d  = cnt_b;
						last_d = evt.count_now;
						case (pat_b)
							ewjt_pkg::PAT_NONE: begin
								just_d = 1'b1;
								pat_d  = ewjt_pkg::PAT_BWD_EXPECT_FWD;
							end
							ewjt_pkg::PAT_FWD_EXPECT_BWD: begin
								pat_d = ewjt_pkg::PAT_BWD_EXPECT_FWD_E;
							end
							ewjt_pkg::PAT_FWD_EXPECT_BWD_E: begin
								cnt_d  = just_b ? ewjt_pkg::sat_inc(cnt_inc) : cnt_inc;
								just_d = 1'b0;
								pat_d  = ewjt_pkg::PAT_BWD_EXPECT_FWD;
								if (cfg.confirm_threshold <= cnt_d) begin
									comp_d = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
		endcase

		nxt.direction     = dir_d;
		nxt.wrap_count    = wraps_d;
		nxt.pattern_state = pat_d;
		nxt.pattern_count = cnt_d;
		nxt.compensating  = comp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= ewjt_pkg::DIR_UNKNOWN;
			wraps_q <= '0;
			pat_q   <= ewjt_pkg::PAT_NONE;
			cnt_q   <= '0;
			just_q  <= 1'b0;
			comp_q  <= 1'b0;
			last_q  <= '0;
		end else if (step) begin
			dir_q   <= dir_d;
			wraps_q <= wraps_d;
			pat_q   <= pat_d;
			cnt_q   <= cnt_d;
			just_q  <= just_d;
			comp_q  <= comp_d;
			last_q  <= last_d;
		end
	end

endmodule

[hdl/encoder_wrap_and_jitter_tracker.sv]
// Encoder wrap counter with back-and-forth jitter detection.
// A status word is valid in the cycle after its event word is accepted.
// Takes one event word per cycle while the status register frees as it is taken.
// Reset clears the configuration, all tracker state and the output valid.
// Depends on ewjt_pkg and ewjt_core.
module encoder_wrap_and_jitter_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	output logic                           evt_ready,
	input  ewjt_pkg::evt_word_t            evt,
	output logic                           status_valid,
	input  logic                           status_ready,
	output ewjt_pkg::status_word_t         status,
	input  logic                           cfg_we,
	input  logic [ewjt_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [ewjt_pkg::CfgDataW-1:0]  cfg_wdata
);

	ewjt_pkg::cfg_t         cfg_q;
	ewjt_pkg::status_word_t nxt;
	ewjt_pkg::status_word_t status_q;
	logic                   status_valid_q;
	logic                   step;

	assign evt_ready    = !status_valid_q || status_ready;
	assign step         = evt_valid && evt_ready;
	assign status_valid = status_valid_q;
	assign status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ewjt_pkg::CFG_INVERT_MODE: begin
					cfg_q.invert_mode <= cfg_wdata[0];
				end
				ewjt_pkg::CFG_PATTERN_CHECK_EN: begin
					cfg_q.pattern_check_enable <= cfg_wdata[0];
				end
				ewjt_pkg::CFG_CONFIRM_THRESHOLD: begin
					cfg_q.confirm_threshold <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	ewjt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.evt    (evt),
		.cfg    (cfg_q),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (evt_ready) begin
			status_valid_q <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_q <= nxt;
		end
	end

endmodule
